/* design/thpd_pkg.sv */
// thpd_pkg: shared widths, mode and command codes, register indexes and reset
// values for the thermostat heat-pump decision unit
// no dependencies
package thpd_pkg;

   // field widths
   localparam int TempW     = 11;
   localparam int SetW      = 9;
   localparam int BandW     = 7;
   localparam int ModeW     = 3;
   localparam int HourW     = 5;
   localparam int SinceW    = 16;
   localparam int CountW    = 8;
   localparam int CmdW      = 2;
   localparam int WindowW   = 10;
   localparam int HoursW    = 10;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 10;
   // signed width wide enough for target plus or minus band or margin
   localparam int CalcW     = 12;

   // operating mode codes
   localparam logic [ModeW-1:0] OP_OFF       = 3'd0;
   localparam logic [ModeW-1:0] OP_AUTO      = 3'd1;
   localparam logic [ModeW-1:0] OP_FORCED    = 3'd2;
   localparam logic [ModeW-1:0] OP_ECO       = 3'd3;
   localparam logic [ModeW-1:0] OP_COMFORT   = 3'd4;
   localparam logic [ModeW-1:0] OP_FROSTFREE = 3'd5;

   // calendar mode codes
   localparam logic [ModeW-1:0] CAL_OFF       = 3'd0;
   localparam logic [ModeW-1:0] CAL_ECO       = 3'd1;
   localparam logic [ModeW-1:0] CAL_COMFORT   = 3'd2;
   localparam logic [ModeW-1:0] CAL_FROSTFREE = 3'd3;

   // effective mode after calendar resolution
   typedef enum logic [2:0] {
      EFF_OFF,
      EFF_FORCED,
      EFF_ECO,
      EFF_COMFORT,
      EFF_FROSTFREE,
      EFF_NONE
   } eff_mode_type;

   // pump commands
   localparam logic [CmdW-1:0] CMD_NONE = 2'd0;
   localparam logic [CmdW-1:0] CMD_RUN  = 2'd1;
   localparam logic [CmdW-1:0] CMD_STOP = 2'd2;

   // configuration register indexes
   localparam logic [CsrIndexW-1:0] REG_ECO_SETPOINT       = 3'd0;
   localparam logic [CsrIndexW-1:0] REG_FROSTFREE_SETPOINT = 3'd1;
   localparam logic [CsrIndexW-1:0] REG_COMFORT_SETPOINT   = 3'd2;
   localparam logic [CsrIndexW-1:0] REG_HYSTERESIS_BAND    = 3'd3;
   localparam logic [CsrIndexW-1:0] REG_OVERSHOOT_MARGIN   = 3'd4;
   localparam logic [CsrIndexW-1:0] REG_PRESENCE_WINDOW    = 3'd5;
   localparam logic [CsrIndexW-1:0] REG_PRESENCE_ENABLE    = 3'd6;
   localparam logic [CsrIndexW-1:0] REG_PRESENCE_HOURS     = 3'd7;

   // register reset values
   localparam logic [SetW-1:0]    RST_ECO       = 9'd160;
   localparam logic [SetW-1:0]    RST_FROSTFREE = 9'd120;
   localparam logic [SetW-1:0]    RST_COMFORT   = 9'd190;
   localparam logic [BandW-1:0]   RST_BAND      = 7'd5;
   localparam logic [BandW-1:0]   RST_MARGIN    = 7'd5;
   localparam logic [WindowW-1:0] RST_WINDOW    = 10'd30;
   localparam logic [HoursW-1:0]  RST_HOURS     = 10'd648;

   // presence needs more than this many motion detections
   localparam logic [CountW-1:0] MOTION_MIN = 8'd2;

endpackage

/* design/thermostat_heat_pump_decision_unit.sv */
// thermostat_heat_pump_decision_unit: per-tick heat-pump command decision
// depends on thpd_pkg
//
// Usage:
//   req_ channel carries one minute-tick beat: room temperature, pump state
//   and setpoint, user and calendar modes, forced setpoint, hour and motion
//   data. rsp_ channel returns exactly one beat per request: pump command,
//   command setpoint, mode target and presence boost flag.
//   csr_ channel writes the eight configuration registers by index; it is
//   always ready and should only be written while no request is in flight.
//   A request goes into the input register stage, then the decision logic
//   feeds the response register. Throughput is one beat per cycle while
//   rsp_ready is high; both stages advance independently, so
//   a new request is taken while a finished response waits.
//   When the receiver stalls, the response register holds and the input
//   stage fills; req_ready drops only once both stages are occupied.
//   Synchronous active-high reset empties both stages and loads the
//   configuration registers with their default values.
module thermostat_heat_pump_decision_unit
   import thpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [TempW-1:0]  req_room_temp,
   input  logic                     req_pump_running,
   input  logic [SetW-1:0]          req_pump_setpoint,
   input  logic [ModeW-1:0]         req_operating_mode,
   input  logic [ModeW-1:0]         req_calendar_mode,
   input  logic [SetW-1:0]          req_forced_setpoint,
   input  logic [HourW-1:0]         req_hour_now,
   input  logic [SinceW-1:0]        req_seconds_since_motion,
   input  logic [CountW-1:0]        req_motion_count,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CmdW-1:0]          rsp_pump_command,
   output logic [SetW-1:0]          rsp_command_setpoint,
   output logic [SetW-1:0]          rsp_target_setpoint,
   output logic                     rsp_presence_boost,
   // configuration channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexW-1:0]     csr_index,
   input  logic [CsrDataW-1:0]      csr_data
);

   // configuration registers
   logic [SetW-1:0]    eco_ff, frost_ff, comfort_ff;
   logic [BandW-1:0]   band_ff, margin_ff;
   logic [WindowW-1:0] window_ff;
   logic               enable_ff;
   logic [HoursW-1:0]  hours_ff;

   // input stage
   logic                    in_valid_ff;
   logic signed [TempW-1:0] temp_ff;
   logic                    running_ff;
   logic [SetW-1:0]         hp_set_ff;
   logic [ModeW-1:0]        op_ff, cal_ff;
   logic [SetW-1:0]         forced_ff;
   logic [HourW-1:0]        hour_ff;
   logic [SinceW-1:0]       since_ff;
   logic [CountW-1:0]       count_ff;

   // response stage
   logic            out_valid_ff;
   logic [CmdW-1:0] cmd_ff, cmd_in;
   logic [SetW-1:0] cmd_set_ff, cmd_set_in;
   logic [SetW-1:0] target_ff, target_in;
   logic            boost_ff, boost_in;

   logic out_free;
   logic in_free;
   logic req_beat;
   logic move_beat;

   // decision signals
   eff_mode_type            eff_mode;
   logic [SetW-1:0]         goal;
   logic [SinceW-1:0]       window_secs;
   logic [HourW-1:0]        first_hour, last_hour;
   logic                    presence;
   logic signed [CalcW-1:0] temp_x, goal_x, hp_set_x, band_x, margin_x;
   logic signed [CalcW-1:0] goal_lo, goal_hi, goal_stop;
   logic                    is_off;

   // handshake and stage flow
   assign out_free  = !out_valid_ff || rsp_ready;
   assign in_free   = !in_valid_ff || out_free;
   assign req_ready = in_free;
   assign req_beat  = req_valid && in_free;
   assign move_beat = in_valid_ff && out_free;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         eco_ff    <= RST_ECO;
         frost_ff  <= RST_FROSTFREE;
         comfort_ff <= RST_COMFORT;
         band_ff   <= RST_BAND;
         margin_ff <= RST_MARGIN;
         window_ff <= RST_WINDOW;
         enable_ff <= 1'b0;
         hours_ff  <= RST_HOURS;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ECO_SETPOINT:       eco_ff     <= csr_data[SetW-1:0];
            REG_FROSTFREE_SETPOINT: frost_ff   <= csr_data[SetW-1:0];
            REG_COMFORT_SETPOINT:   comfort_ff <= csr_data[SetW-1:0];
            REG_HYSTERESIS_BAND:    band_ff    <= csr_data[BandW-1:0];
            REG_OVERSHOOT_MARGIN:   margin_ff  <= csr_data[BandW-1:0];
            REG_PRESENCE_WINDOW:    window_ff  <= csr_data[WindowW-1:0];
            REG_PRESENCE_ENABLE:    enable_ff  <= csr_data[0];
            REG_PRESENCE_HOURS:     hours_ff   <= csr_data[HoursW-1:0];
            default: ;
         endcase
      end
   end

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         temp_ff    <= req_room_temp;
         running_ff <= req_pump_running;
         hp_set_ff  <= req_pump_setpoint;
         op_ff      <= req_operating_mode;
         cal_ff     <= req_calendar_mode;
         forced_ff  <= req_forced_setpoint;
         hour_ff    <= req_hour_now;
         since_ff   <= req_seconds_since_motion;
         count_ff   <= req_motion_count;
      end
   end

   // effective mode: auto follows the calendar
   always_comb begin
      eff_mode = EFF_NONE;
      case (op_ff)
         OP_OFF:       eff_mode = EFF_OFF;
         OP_FORCED:    eff_mode = EFF_FORCED;
         OP_ECO:       eff_mode = EFF_ECO;
         OP_COMFORT:   eff_mode = EFF_COMFORT;
         OP_FROSTFREE: eff_mode = EFF_FROSTFREE;
         OP_AUTO: begin
            case (cal_ff)
               CAL_OFF:       eff_mode = EFF_OFF;
               CAL_ECO:       eff_mode = EFF_ECO;
               CAL_COMFORT:   eff_mode = EFF_COMFORT;
               CAL_FROSTFREE: eff_mode = EFF_FROSTFREE;
               default:       eff_mode = EFF_NONE;
            endcase
         end
         default: eff_mode = EFF_NONE;
      endcase
   end

   // mode target
   always_comb begin
      case (eff_mode)
         EFF_FORCED:    target_in = forced_ff;
         EFF_ECO:       target_in = eco_ff;
         EFF_COMFORT:   target_in = comfort_ff;
         EFF_FROSTFREE: target_in = frost_ff;
         default:       target_in = '0;
      endcase
   end

   // presence test: window in seconds is minutes * 64 - minutes * 4
   assign window_secs = ({{(SinceW-WindowW){1'b0}}, window_ff} << 6)
                      - ({{(SinceW-WindowW){1'b0}}, window_ff} << 2);
   assign first_hour  = hours_ff[HourW-1:0];
   assign last_hour   = hours_ff[2*HourW-1:HourW];
   assign presence    = enable_ff && (hour_ff >= first_hour) && (hour_ff <= last_hour)
                     && (since_ff <= window_secs) && (count_ff > MOTION_MIN)
                     && (eff_mode == EFF_ECO);
   assign goal        = presence ? comfort_ff : target_in;

   // widened signed operands for the thresholds
   assign temp_x    = CalcW'(temp_ff);
   assign goal_x    = $signed({{(CalcW-SetW){1'b0}}, goal});
   assign hp_set_x  = $signed({{(CalcW-SetW){1'b0}}, hp_set_ff});
   assign band_x    = $signed({{(CalcW-BandW){1'b0}}, band_ff});
   assign margin_x  = $signed({{(CalcW-BandW){1'b0}}, margin_ff});
   assign goal_lo   = goal_x - band_x;
   assign goal_hi   = goal_x + band_x;
   assign goal_stop = goal_x + margin_x;
   assign is_off    = (eff_mode == EFF_OFF);

   // command selection; cold or zero reading gives no command
   always_comb begin
      cmd_in   = CMD_NONE;
      boost_in = 1'b0;
      if (temp_ff > 0) begin
         boost_in = presence;
         if (!is_off && !running_ff && (temp_x <= goal_lo)) begin
            cmd_in = CMD_RUN;
         end else if (is_off && running_ff) begin
            cmd_in = CMD_STOP;
         end else if (running_ff && (temp_x >= goal_stop)) begin
            cmd_in = CMD_STOP;
         end else if (running_ff && ((hp_set_x > goal_hi) || (hp_set_x < goal_lo))) begin
            cmd_in = CMD_RUN;
         end
      end
      cmd_set_in = (cmd_in == CMD_RUN) ? goal : '0;
   end

   // response register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // response register payload
   always_ff @(posedge clock) begin
      if (move_beat) begin
         cmd_ff     <= cmd_in;
         cmd_set_ff <= cmd_set_in;
         target_ff  <= target_in;
         boost_ff   <= boost_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_pump_command     = cmd_ff;
   assign rsp_command_setpoint = cmd_set_ff;
   assign rsp_target_setpoint  = target_ff;
   assign rsp_presence_boost   = boost_ff;

`ifndef NO_ASSERTIONS
   // a loaded input stage that cannot move on keeps its beat
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("input stage dropped a stalled beat");

   // only a run command carries a setpoint
   a_setpoint_run: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (cmd_ff != CMD_RUN)) |-> (cmd_set_ff == '0))
      else $error("setpoint without run command");

   // boost only comes from eco mode, so the target is the eco setpoint
   a_boost_eco: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && boost_ff) |-> (target_ff == eco_ff))
      else $error("presence boost outside eco mode");

   // never an undefined command code
   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((cmd_ff == CMD_NONE) || (cmd_ff == CMD_RUN) || (cmd_ff == CMD_STOP)))
      else $error("undefined pump command");
`endif

endmodule
